@@ rtl/core/srecord_serial_loader_macros.svh @@
// ----------------------------------------------------------------------------
// S-record loader assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SRECORD_SERIAL_LOADER_MACROS_SVH
`define SRECORD_SERIAL_LOADER_MACROS_SVH

// same-cycle implication
`define SSL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssl assertion failed");

// next-cycle implication
`define SSL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssl assertion failed");

`endif

@@ rtl/core/ssl_pkg.sv @@
// ----------------------------------------------------------------------------
// S-record loader package
// Command and result codes, character constants and the queue entry type.
// ----------------------------------------------------------------------------
package ssl_pkg;

  typedef enum logic [1:0] {
    CMD_ECHO   = 2'd0,
    CMD_PROMPT = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_JUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_JUMP  = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  byte_val;
    logic [31:0] addr;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [7:0] CH_S       = 8'h53;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CASE_FOLD  = 8'h20;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  localparam logic [9:0] POS_MAX      = 10'd1023;
  localparam logic [7:0] NO_ADDR_END  = 8'hFF;
  localparam logic [9:0] REC_END_INIT = 10'd2;
  localparam logic [7:0] ADDR_END_OFS = 8'd5;

  localparam logic [31:0] PROMPT_LO   = 32'h76720A0D;
  localparam logic [31:0] PROMPT_HI   = 32'h203E3233;
  localparam logic [3:0]  PROMPT_LAST = 4'd8;

  function automatic logic [7:0] prompt_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = CH_CR;
      4'd1:    ch = PROMPT_LO[7:0];
      4'd2:    ch = PROMPT_LO[15:8];
      4'd3:    ch = PROMPT_LO[23:16];
      4'd4:    ch = PROMPT_LO[31:24];
      4'd5:    ch = PROMPT_HI[7:0];
      4'd6:    ch = PROMPT_HI[15:8];
      4'd7:    ch = PROMPT_HI[23:16];
      4'd8:    ch = PROMPT_HI[31:24];
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/ssl_front.sv @@
// ----------------------------------------------------------------------------
// S-record loader front end
// Accepts serial bytes, tracks record parsing state and issues commands.
// ----------------------------------------------------------------------------
module ssl_front import ssl_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] rx_byte,
  input  q_stat_t    q_stat,
  output logic       ent_push,
  output entry_t     ent
);

  logic                 outside, outside_next;
  logic [9:0]           pos, pos_next;
  logic [7:0]           aend, aend_next;
  logic [9:0]           rend, rend_next;
  logic [31:0]          acc, acc_next;
  logic [ADDR_BITS-1:0] wp, wp_next;
  logic [ADDR_BITS-1:0] start, start_next;
  logic                 start_valid, start_valid_next;

  logic        accept;
  logic [7:0]  cu;
  logic [7:0]  diff;
  logic [3:0]  nib;
  logic [31:0] acc_sh;
  logic [9:0]  pos_inc;
  logic        loads;

  always_comb begin
    accept           = push && !q_stat.full;
    outside_next     = outside;
    pos_next         = pos;
    aend_next        = aend;
    rend_next        = rend;
    acc_next         = acc;
    wp_next          = wp;
    start_next       = start;
    start_valid_next = start_valid;
    ent_push         = 1'b0;
    ent.cmd          = CMD_ECHO;
    ent.byte_val     = '0;
    ent.addr         = '0;

    cu      = (rx_byte >= CH_LOWER_A) ? rx_byte - CASE_FOLD : rx_byte;
    diff    = (cu >= CH_UPPER_A) ? cu - CH_UPPER_A + HEX_TEN : cu - CH_ZERO;
    nib     = diff[3:0];
    acc_sh  = {acc[27:0], nib};
    pos_inc = (pos < POS_MAX) ? pos + 10'd1 : pos;
    loads   = (aend == 8'd7) || (aend == 8'd9) || (aend == 8'd11);

    if (accept) begin
      if (outside) begin
        acc_next = '0;
        if (rx_byte == CH_S) begin
          outside_next = 1'b0;
          pos_next     = '0;
        end else if (rx_byte == CH_CR) begin
          ent_push  = 1'b1;
          ent.cmd   = CMD_PROMPT;
          pos_next  = '0;
          aend_next = NO_ADDR_END;
          rend_next = REC_END_INIT;
        end else if (rx_byte >= CH_SPACE) begin
          ent_push     = 1'b1;
          ent.byte_val = rx_byte;
        end
      end else if (rx_byte inside {[CH_LF:CH_CR]}) begin
        // abandon the record
        outside_next = 1'b1;
        pos_next     = '0;
        aend_next    = NO_ADDR_END;
        rend_next    = REC_END_INIT;
        acc_next     = '0;
      end else begin
        acc_next = acc_sh;
        pos_next = pos_inc;
        if (pos_inc == 10'd1) begin
          acc_next = '0;
          if (acc_sh >= 32'd7 && acc_sh <= 32'd9) begin
            ent_push     = 1'b1;
            ent.cmd      = CMD_JUMP;
            ent.addr     = 32'(start);
            outside_next = 1'b1;
            pos_next     = '0;
            aend_next    = NO_ADDR_END;
            rend_next    = REC_END_INIT;
          end else if (acc_sh <= 32'd3) begin
            aend_next = {5'd0, acc_sh[1:0], 1'b0} + ADDR_END_OFS;
          end
        end else if (pos_inc == 10'd3) begin
          rend_next = rend + {1'b0, acc_sh[7:0], 1'b0};
          acc_next  = '0;
        end else if (loads) begin
          if (pos_inc == {2'b00, aend}) begin
            wp_next = acc_sh[ADDR_BITS-1:0];
            if (!start_valid) begin
              start_next       = acc_sh[ADDR_BITS-1:0];
              start_valid_next = 1'b1;
            end
          end else if (pos_inc > {2'b00, aend} && pos_inc[0] && pos_inc < rend) begin
            ent_push     = 1'b1;
            ent.cmd      = CMD_WRITE;
            ent.byte_val = acc_sh[7:0];
            ent.addr     = 32'(wp);
            wp_next      = wp + ADDR_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outside     <= 1'b1;
      pos         <= '0;
      aend        <= NO_ADDR_END;
      rend        <= REC_END_INIT;
      acc         <= '0;
      wp          <= '0;
      start       <= '0;
      start_valid <= 1'b0;
    end else begin
      outside     <= outside_next;
      pos         <= pos_next;
      aend        <= aend_next;
      rend        <= rend_next;
      acc         <= acc_next;
      wp          <= wp_next;
      start       <= start_next;
      start_valid <= start_valid_next;
    end
  end

endmodule

@@ rtl/core/ssl_queue.sv @@
// ----------------------------------------------------------------------------
// S-record loader command queue
// Short register queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module ssl_queue import ssl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  entry_t  wr_ent,
  input  logic    rd_en,
  output entry_t  head,
  output q_stat_t q_stat
);

  entry_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   cnt;

  assign head         = mem[rd_ptr];
  assign q_stat.full  = (cnt == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt == '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt <= cnt + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/ssl_back.sv @@
// ----------------------------------------------------------------------------
// S-record loader result sequencer
// Expands queued commands into result items and holds the output register.
// ----------------------------------------------------------------------------
`include "srecord_serial_loader_macros.svh"

module ssl_back import ssl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  q_stat_t     q_stat,
  input  logic        pop,
  output logic        q_pop,
  output logic        empty,
  output logic [1:0]  kind,
  output logic [7:0]  out_char,
  output logic [31:0] address,
  output logic [7:0]  data,
  output logic        last
);

  logic       out_valid;
  logic       out_load;
  logic [3:0] idx, idx_next;
  kind_t      kind_next;
  logic [7:0] char_next;
  logic [31:0] addr_next;
  logic [7:0] data_next;
  logic       last_next;

  assign empty    = !out_valid;
  assign out_load = !q_stat.empty && (!out_valid || pop);

  always_comb begin
    idx_next  = idx;
    q_pop     = 1'b0;
    kind_next = KIND_CHAR;
    char_next = '0;
    addr_next = '0;
    data_next = '0;
    last_next = 1'b1;
    case (head.cmd)
      CMD_ECHO: begin
        char_next = head.byte_val;
      end
      CMD_PROMPT: begin
        char_next = prompt_char(idx);
        last_next = (idx == PROMPT_LAST);
      end
      CMD_WRITE: begin
        kind_next = KIND_WRITE;
        addr_next = head.addr;
        data_next = head.byte_val;
      end
      CMD_JUMP: begin
        kind_next = KIND_JUMP;
        addr_next = head.addr;
      end
      default: begin
        char_next = '0;
      end
    endcase
    if (out_load) begin
      if (head.cmd == CMD_PROMPT && idx != PROMPT_LAST) begin
        idx_next = idx + 4'd1;
      end else begin
        idx_next = '0;
        q_pop    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      idx <= idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind     <= kind_next;
      out_char <= char_next;
      address  <= addr_next;
      data     <= data_next;
      last     <= last_next;
    end
  end

  `SSL_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty)
  `SSL_ASSERT_NOW(a_idx_in_prompt, idx != 4'd0, !q_stat.empty && head.cmd == CMD_PROMPT)
  `SSL_ASSERT_NOW(a_single_last, out_valid && kind != KIND_CHAR, last)
  `SSL_ASSERT_NEXT(a_idx_hold, !out_load, $stable(idx))

endmodule

@@ rtl/core/srecord_serial_loader.sv @@
// ----------------------------------------------------------------------------
// S-record serial loader
// Parses S-records from serial bytes into echo, memory write and jump items.
//
//   channel  | handshake     | fields
//   ---------+---------------+-----------------------------------------
//   input    | push / full   | rx_byte
//   result   | empty / pop   | kind, out_char, address, data, last
//
// One byte is accepted per cycle while the 4-entry command queue has room,
// and parsed in that cycle; its first result goes through the queue and the
// output register to the ports. The back end sends one result item per cycle
// while pop keeps up: 9 for a CR outside a record, at most 1 for any other byte.
// Reset is synchronous with no clearing pass; bytes are taken from the first
// edge with rst low. A low pop stalls the back end; bytes flow until the queue fills.
// ----------------------------------------------------------------------------
module srecord_serial_loader import ssl_pkg::*; #(
  parameter int ADDR_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  out_char,
  output logic [31:0] address,
  output logic [7:0]  data,
  output logic        last
);

  q_stat_t q_stat;
  entry_t  ent;
  entry_t  head;
  logic    ent_push;
  logic    q_pop;

  assign full = q_stat.full;

  ssl_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .q_stat   (q_stat),
    .ent_push (ent_push),
    .ent      (ent)
  );

  ssl_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (ent_push),
    .wr_ent (ent),
    .rd_en  (q_pop),
    .head   (head),
    .q_stat (q_stat)
  );

  ssl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .q_pop    (q_pop),
    .empty    (empty),
    .kind     (kind),
    .out_char (out_char),
    .address  (address),
    .data     (data),
    .last     (last)
  );

endmodule
